// ----- sv/scb_pkg.sv -----
// Shared request codes and register map of the scaled color-key sprite blitter.
package scb_pkg;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TEXEL = 1'b1;

  localparam int REG_IDX_BITS = 3;
  localparam int ADDR_BITS    = REG_IDX_BITS + 2;
  localparam int DATA_BITS    = 32;

  localparam logic [REG_IDX_BITS-1:0] REG_DEST_WIDTH    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DEST_HEIGHT   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_TEX_WIDTH     = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_TEX_HEIGHT    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_KEY_COLOR     = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd6;

endpackage

// ----- sv/scaled_colorkey_sprite_blit.sv -----
// Top level of the scaled color-key sprite blitter: register file, front end, back end, output queue.
// The blitter accepts one request per cycle while no row search runs and the output queue has room,
// and returns one result per request, in order. A texel request that ends a row (but not the
// last row), and a start request of a nonempty blit, when the texture is not upscaled
// vertically, also run the texture row search, which examines one texture row per cycle (the
// last row it may examine waits for room in the output queue); the search gives up after 8192
// rows when no row is ever sampled. A result passes through the input queue, the stepping
// unit and the row search to the output queue; two-entry queues on both sides let the two
// channels stall on their own.
module scaled_colorkey_sprite_blit import scb_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_tex_origin_x,
  input  logic [COORD_BITS-1:0] in_tex_origin_y,
  input  logic [PIXEL_BITS-1:0] in_texel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_write_enable,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [PIXEL_BITS-1:0] out_pixel_data,
  output logic [COORD_BITS:0]   out_fetch_x,
  output logic [COORD_BITS:0]   out_fetch_y,
  output logic                  out_done_res
);

  localparam int C         = COORD_BITS;
  localparam int W         = C + 1;
  localparam int ITEM_BITS = 2 + 2 * W + 4 * C + PIXEL_BITS;
  localparam int OUT_BITS  = 2 + 2 * C + PIXEL_BITS + 2 * W;

  logic [C-1:0]          dest_w_r, dest_h_r, tex_w_r, tex_h_r;
  logic [PIXEL_BITS-1:0] key_r;
  logic [W-1:0]          screen_w_r, screen_h_r;
  logic                  cfg_wr;
  logic [REG_IDX_BITS-1:0] reg_idx;

  logic                  item_valid, item_ready;
  logic [ITEM_BITS-1:0]  item_data;

  logic                  res_valid, res_ready;
  logic                  res_we, res_done;
  logic [C-1:0]          res_px, res_py;
  logic [PIXEL_BITS-1:0] res_data;
  logic [W-1:0]          res_fx, res_fy;
  logic [OUT_BITS-1:0]   res_packed, out_packed;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_w_r   <= C'(1);
      dest_h_r   <= C'(1);
      tex_w_r    <= C'(1);
      tex_h_r    <= C'(1);
      key_r      <= '0;
      screen_w_r <= W'(1) << C;
      screen_h_r <= W'(1) << C;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEST_WIDTH:    dest_w_r   <= pwdata[C-1:0];
        REG_DEST_HEIGHT:   dest_h_r   <= pwdata[C-1:0];
        REG_TEX_WIDTH:     tex_w_r    <= pwdata[C-1:0];
        REG_TEX_HEIGHT:    tex_h_r    <= pwdata[C-1:0];
        REG_KEY_COLOR:     key_r      <= pwdata[PIXEL_BITS-1:0];
        REG_SCREEN_WIDTH:  screen_w_r <= pwdata[W-1:0];
        REG_SCREEN_HEIGHT: screen_h_r <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEST_WIDTH:    prdata = DATA_BITS'(dest_w_r);
      REG_DEST_HEIGHT:   prdata = DATA_BITS'(dest_h_r);
      REG_TEX_WIDTH:     prdata = DATA_BITS'(tex_w_r);
      REG_TEX_HEIGHT:    prdata = DATA_BITS'(tex_h_r);
      REG_KEY_COLOR:     prdata = DATA_BITS'(key_r);
      REG_SCREEN_WIDTH:  prdata = DATA_BITS'(screen_w_r);
      REG_SCREEN_HEIGHT: prdata = DATA_BITS'(screen_h_r);
      default:           prdata = '0;
    endcase
  end

  scb_front #(
    .COORD_BITS(COORD_BITS),
    .PIXEL_BITS(PIXEL_BITS),
    .ITEM_BITS (ITEM_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_tex_origin_x(in_tex_origin_x),
    .in_tex_origin_y(in_tex_origin_y),
    .in_texel       (in_texel),
    .dest_w         (dest_w_r),
    .dest_h         (dest_h_r),
    .screen_w       (screen_w_r),
    .screen_h       (screen_h_r),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item_data      (item_data)
  );

  scb_back #(
    .COORD_BITS(COORD_BITS),
    .PIXEL_BITS(PIXEL_BITS),
    .ITEM_BITS (ITEM_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item_data       (item_data),
    .dest_w          (dest_w_r),
    .dest_h          (dest_h_r),
    .tex_w           (tex_w_r),
    .tex_h           (tex_h_r),
    .key_color       (key_r),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res_write_enable(res_we),
    .res_pixel_x     (res_px),
    .res_pixel_y     (res_py),
    .res_pixel_data  (res_data),
    .res_fetch_x     (res_fx),
    .res_fetch_y     (res_fy),
    .res_done        (res_done)
  );

  assign res_packed = {res_we, res_px, res_py, res_data, res_fx, res_fy, res_done};

  scb_fifo #(
    .WIDTH(OUT_BITS),
    .DEPTH(2)
  ) u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_data  (res_packed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_packed)
  );

  assign {out_write_enable, out_pixel_x, out_pixel_y, out_pixel_data, out_fetch_x,
          out_fetch_y, out_done_res} = out_packed;

endmodule

// ----- sv/scb_fifo.sv -----
// Small flip-flop queue with valid/ready on both sides.
module scb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_ready  = (cnt_r != CW'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// ----- sv/scb_front.sv -----
// Front end: accepts requests, works out clip bounds of a start and queues the result.
module scb_front import scb_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 32,
  parameter int ITEM_BITS  = 2 + 2 * (COORD_BITS + 1) + 4 * COORD_BITS + PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_tex_origin_x,
  input  logic [COORD_BITS-1:0] in_tex_origin_y,
  input  logic [PIXEL_BITS-1:0] in_texel,
  input  logic [COORD_BITS-1:0] dest_w,
  input  logic [COORD_BITS-1:0] dest_h,
  input  logic [COORD_BITS:0]   screen_w,
  input  logic [COORD_BITS:0]   screen_h,
  output logic                  item_valid,
  input  logic                  item_ready,
  output logic [ITEM_BITS-1:0]  item_data
);

  localparam int W = COORD_BITS + 1;

  logic [W-1:0]         x_sum, y_sum;
  logic [W-1:0]         col_end, row_end;
  logic                 nonempty;
  logic                 kind;
  logic [ITEM_BITS-1:0] packed_item;

  assign kind     = (in_req_type == REQ_START) ? REQ_START : REQ_TEXEL;
  assign x_sum    = W'(in_start_x) + W'(dest_w);
  assign y_sum    = W'(in_start_y) + W'(dest_h);
  assign col_end  = (x_sum < screen_w) ? x_sum : screen_w;
  assign row_end  = (y_sum < screen_h) ? y_sum : screen_h;
  assign nonempty = (W'(in_start_x) < col_end) && (W'(in_start_y) < row_end);

  assign packed_item = {kind, nonempty, col_end, row_end, in_start_x, in_start_y,
                        in_tex_origin_x, in_tex_origin_y, in_texel};

  scb_fifo #(
    .WIDTH(ITEM_BITS),
    .DEPTH(2)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (packed_item),
    .out_valid(item_valid),
    .out_ready(item_ready),
    .out_data (item_data)
  );

endmodule

// ----- sv/scb_back.sv -----
// Back end: Bresenham stepping over the destination rectangle and the texture row search.
module scb_back import scb_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 32,
  parameter int ITEM_BITS  = 2 + 2 * (COORD_BITS + 1) + 4 * COORD_BITS + PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [ITEM_BITS-1:0]  item_data,
  input  logic [COORD_BITS-1:0] dest_w,
  input  logic [COORD_BITS-1:0] dest_h,
  input  logic [COORD_BITS-1:0] tex_w,
  input  logic [COORD_BITS-1:0] tex_h,
  input  logic [PIXEL_BITS-1:0] key_color,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_write_enable,
  output logic [COORD_BITS-1:0] res_pixel_x,
  output logic [COORD_BITS-1:0] res_pixel_y,
  output logic [PIXEL_BITS-1:0] res_pixel_data,
  output logic [COORD_BITS:0]   res_fetch_x,
  output logic [COORD_BITS:0]   res_fetch_y,
  output logic                  res_done
);

  localparam int C = COORD_BITS;
  localparam int W = C + 1;
  localparam int E = C + 2;
  localparam int S = C + 4;

  logic                  it_kind, it_nonempty;
  logic [W-1:0]          it_col_end, it_row_end;
  logic [C-1:0]          it_sx, it_sy, it_tox, it_toy;
  logic [PIXEL_BITS-1:0] it_texel;

  logic         busy_r, busy_nxt;
  logic         srch_r, srch_nxt;
  logic [W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [W-1:0] tex_col_r, tex_col_nxt, tex_row_r, tex_row_nxt;
  logic [W-1:0] rcs_r, rcs_nxt, rtcs_r, rtcs_nxt;
  logic [E-1:0] err_x_r, err_x_nxt, err_y_r, err_y_nxt;
  logic [W-1:0] col_end_r, col_end_nxt, row_end_r, row_end_nxt;

  logic                  pend_we_r, pend_we_nxt;
  logic [C-1:0]          pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic [PIXEL_BITS-1:0] pend_data_r, pend_data_nxt;

  logic         x_up, y_up, take;
  logic [S-1:0] ex_ext, ey_ext;
  logic [C-1:0] add_x, sub_x;
  logic [S-1:0] sum_x, sum_yr, sum_ys;
  logic         hit_x, hit_yr, hit_ys, s_final;
  logic [E-1:0] err_x_new, err_yr_new, err_ys_new;
  logic         emit, wr_en, row_done;
  logic [W-1:0] col_step, tex_col_xup, row_inc, rb_tex_col;

  logic                  o_we;
  logic [C-1:0]          o_x, o_y;
  logic [PIXEL_BITS-1:0] o_data;

  assign {it_kind, it_nonempty, it_col_end, it_row_end, it_sx, it_sy, it_tox, it_toy,
          it_texel} = item_data;

  assign x_up = (tex_w < dest_w);
  assign y_up = (tex_h < dest_h);

  assign item_ready = !srch_r && res_ready;
  assign take       = item_valid && item_ready;

  assign ex_ext = {{(S - E){err_x_r[E-1]}}, err_x_r};
  assign ey_ext = {{(S - E){err_y_r[E-1]}}, err_y_r};

  assign add_x     = x_up ? tex_w : dest_w;
  assign sub_x     = x_up ? dest_w : tex_w;
  assign sum_x     = ex_ext + S'(add_x);
  assign hit_x     = $signed({sum_x, 1'b0}) >= $signed((S + 1)'(sub_x));
  assign err_x_new = hit_x ? E'(sum_x - S'(sub_x)) : E'(sum_x);

  assign sum_yr     = ey_ext + S'(tex_h);
  assign hit_yr     = $signed({sum_yr, 1'b0}) >= $signed((S + 1)'(dest_h));
  assign err_yr_new = hit_yr ? E'(sum_yr - S'(dest_h)) : E'(sum_yr);

  assign sum_ys     = ey_ext + S'(dest_h);
  assign hit_ys     = $signed({sum_ys, 1'b0}) >= $signed((S + 1)'(tex_h));
  assign err_ys_new = hit_ys ? E'(sum_ys - S'(tex_h)) : E'(sum_ys);
  assign s_final    = hit_ys || (cnt_r == '1);

  assign emit        = x_up || hit_x;
  assign wr_en       = emit && (it_texel != key_color);
  assign col_step    = emit ? col_r + W'(1) : col_r;
  assign tex_col_xup = hit_x ? tex_col_r + W'(1) : tex_col_r;
  assign row_done    = (col_step >= col_end_r);
  assign row_inc     = row_r + W'(1);
  assign rb_tex_col  = x_up ? rtcs_r : rtcs_r + W'(1);

  always_comb begin
    busy_nxt      = busy_r;
    srch_nxt      = srch_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    tex_col_nxt   = tex_col_r;
    tex_row_nxt   = tex_row_r;
    rcs_nxt       = rcs_r;
    rtcs_nxt      = rtcs_r;
    err_x_nxt     = err_x_r;
    err_y_nxt     = err_y_r;
    col_end_nxt   = col_end_r;
    row_end_nxt   = row_end_r;
    pend_we_nxt   = pend_we_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    pend_data_nxt = pend_data_r;
    res_valid     = 1'b0;
    o_we          = 1'b0;
    o_x           = col_r[C-1:0];
    o_y           = row_r[C-1:0];
    o_data        = it_texel;
    if (take) begin
      if (it_kind == REQ_START) begin
        rcs_nxt       = W'(it_sx);
        rtcs_nxt      = W'(it_tox);
        row_nxt       = W'(it_sy);
        tex_row_nxt   = W'(it_toy);
        err_y_nxt     = '0;
        col_end_nxt   = it_col_end;
        row_end_nxt   = it_row_end;
        pend_we_nxt   = 1'b0;
        pend_x_nxt    = '0;
        pend_y_nxt    = '0;
        pend_data_nxt = '0;
        if (!it_nonempty) begin
          busy_nxt  = 1'b0;
          res_valid = 1'b1;
        end else if (!y_up) begin
          busy_nxt = 1'b0;
          srch_nxt = 1'b1;
          cnt_nxt  = '0;
        end else begin
          busy_nxt    = 1'b1;
          col_nxt     = W'(it_sx);
          err_x_nxt   = '0;
          tex_col_nxt = x_up ? W'(it_tox) : W'(it_tox) + W'(1);
          res_valid   = 1'b1;
        end
      end else if (busy_r) begin
        res_valid = 1'b1;
        o_we      = wr_en;
        col_nxt   = col_step;
        err_x_nxt = err_x_new;
        if (row_done) begin
          if (y_up) begin
            err_y_nxt = err_yr_new;
            if (hit_yr) begin
              tex_row_nxt = tex_row_r + W'(1);
            end
          end
          row_nxt = row_inc;
          if (row_inc >= row_end_r) begin
            busy_nxt = 1'b0;
          end else if (!y_up) begin
            busy_nxt      = 1'b0;
            srch_nxt      = 1'b1;
            cnt_nxt       = '0;
            res_valid     = 1'b0;
            pend_we_nxt   = wr_en;
            pend_x_nxt    = col_r[C-1:0];
            pend_y_nxt    = row_r[C-1:0];
            pend_data_nxt = it_texel;
          end else begin
            col_nxt     = rcs_r;
            err_x_nxt   = '0;
            tex_col_nxt = rb_tex_col;
          end
        end else begin
          tex_col_nxt = x_up ? tex_col_xup : tex_col_r + W'(1);
        end
      end else begin
        res_valid = 1'b1;
      end
    end else if (srch_r && (!s_final || res_ready)) begin
      tex_row_nxt = tex_row_r + W'(1);
      err_y_nxt   = err_ys_new;
      cnt_nxt     = cnt_r + W'(1);
      o_we        = pend_we_r;
      o_x         = pend_x_r;
      o_y         = pend_y_r;
      o_data      = pend_data_r;
      if (hit_ys) begin
        srch_nxt    = 1'b0;
        busy_nxt    = 1'b1;
        col_nxt     = rcs_r;
        err_x_nxt   = '0;
        tex_col_nxt = rb_tex_col;
        res_valid   = 1'b1;
      end else if (s_final) begin
        srch_nxt  = 1'b0;
        busy_nxt  = 1'b0;
        res_valid = 1'b1;
      end
    end
  end

  assign res_write_enable = o_we;
  assign res_pixel_x      = o_we ? o_x : '0;
  assign res_pixel_y      = o_we ? o_y : '0;
  assign res_pixel_data   = o_we ? o_data : '0;
  assign res_fetch_x      = busy_nxt ? tex_col_nxt : '0;
  assign res_fetch_y      = busy_nxt ? tex_row_nxt : '0;
  assign res_done         = !busy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      srch_r    <= 1'b0;
      cnt_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      tex_col_r <= '0;
      tex_row_r <= '0;
      rcs_r     <= '0;
      rtcs_r    <= '0;
      err_x_r   <= '0;
      err_y_r   <= '0;
      col_end_r <= '0;
      row_end_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      srch_r    <= srch_nxt;
      cnt_r     <= cnt_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      tex_col_r <= tex_col_nxt;
      tex_row_r <= tex_row_nxt;
      rcs_r     <= rcs_nxt;
      rtcs_r    <= rtcs_nxt;
      err_x_r   <= err_x_nxt;
      err_y_r   <= err_y_nxt;
      col_end_r <= col_end_nxt;
      row_end_r <= row_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_we_r   <= pend_we_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_y_r    <= pend_y_nxt;
    pend_data_r <= pend_data_nxt;
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the scaled color-key sprite blitter: directed table, then random blits.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scb_pkg::*;

  localparam int CB = 12;
  localparam int PB = 32;
  localparam int ROW_SEARCH_LIMIT = 8192;
  localparam int QUIET_LIMIT = 40000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic          req_type;
    logic [CB-1:0] start_x;
    logic [CB-1:0] start_y;
    logic [CB-1:0] tex_origin_x;
    logic [CB-1:0] tex_origin_y;
    logic [PB-1:0] texel;
  } blit_req_t;

  typedef struct packed {
    logic          write_enable;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic [PB-1:0] pixel_data;
    logic [CB:0]   fetch_x;
    logic [CB:0]   fetch_y;
    logic          done_res;
  } blit_res_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic [REG_IDX_BITS-1:0]   reg_idx;
    logic [DATA_BITS-1:0]      value;
    blit_req_t                 req;
    bit                        checked;
    blit_res_t                 want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic [CB-1:0]        in_start_x = '0;
  logic [CB-1:0]        in_start_y = '0;
  logic [CB-1:0]        in_tex_origin_x = '0;
  logic [CB-1:0]        in_tex_origin_y = '0;
  logic [PB-1:0]        in_texel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_write_enable;
  logic [CB-1:0]        out_pixel_x;
  logic [CB-1:0]        out_pixel_y;
  logic [PB-1:0]        out_pixel_data;
  logic [CB:0]          out_fetch_x;
  logic [CB:0]          out_fetch_y;
  logic                 out_done_res;

  // Mirror of the blitter registers and stepping state.
  int          dw_reg = 1;
  int          dh_reg = 1;
  int          tw_reg = 1;
  int          th_reg = 1;
  int          sw_reg = 4096;
  int          sh_reg = 4096;
  logic [PB-1:0] key_reg = '0;
  logic [CB:0] col = '0;
  logic [CB:0] row = '0;
  logic [CB:0] tex_col = '0;
  logic [CB:0] tex_row = '0;
  logic [CB:0] row_col_start = '0;
  logic [CB:0] row_tex_col_start = '0;
  logic [CB:0] col_end = '0;
  logic [CB:0] row_end = '0;
  int          err_x = 0;
  int          err_y = 0;
  bit          busy = 1'b0;

  blit_res_t   results_due[$];
  plan_row_t   directed_plan[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  scaled_colorkey_sprite_blit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit advance_to_sampled_row();
    for (int i = 0; i < ROW_SEARCH_LIMIT; i++) begin
      tex_row = tex_row + 1'b1;
      err_y = err_y + dh_reg;
      if (2 * err_y >= th_reg) begin
        err_y = err_y - th_reg;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void begin_row();
    col = row_col_start;
    err_x = 0;
    tex_col = row_tex_col_start;
    if (!(tw_reg < dw_reg)) begin
      tex_col = tex_col + 1'b1;
    end
  endfunction

  function automatic blit_res_t step_blitter(blit_req_t r);
    blit_res_t   res;
    logic [CB:0] px;
    bit          emit;
    int          bound;
    res = '0;
    if (r.req_type == REQ_START) begin
      row_col_start = {1'b0, r.start_x};
      row_tex_col_start = {1'b0, r.tex_origin_x};
      row = {1'b0, r.start_y};
      tex_row = {1'b0, r.tex_origin_y};
      err_y = 0;
      bound = int'(r.start_x) + dw_reg;
      col_end = (bound < sw_reg) ? bound[CB:0] : sw_reg[CB:0];
      bound = int'(r.start_y) + dh_reg;
      row_end = (bound < sh_reg) ? bound[CB:0] : sh_reg[CB:0];
      busy = ({1'b0, r.start_x} < col_end) && ({1'b0, r.start_y} < row_end);
      if (busy && !(th_reg < dh_reg)) begin
        busy = advance_to_sampled_row();
      end
      if (busy) begin
        begin_row();
      end
    end else if (busy) begin
      px = col;
      emit = 1'b0;
      if (tw_reg < dw_reg) begin
        emit = 1'b1;
        col = col + 1'b1;
        err_x = err_x + tw_reg;
        if (2 * err_x >= dw_reg) begin
          tex_col = tex_col + 1'b1;
          err_x = err_x - dw_reg;
        end
      end else begin
        err_x = err_x + dw_reg;
        if (2 * err_x >= tw_reg) begin
          emit = 1'b1;
          col = col + 1'b1;
          err_x = err_x - tw_reg;
        end
      end
      if (emit && r.texel != key_reg) begin
        res.write_enable = 1'b1;
        res.pixel_x = px[CB-1:0];
        res.pixel_y = row[CB-1:0];
        res.pixel_data = r.texel;
      end
      if (col >= col_end) begin
        if (th_reg < dh_reg) begin
          err_y = err_y + th_reg;
          if (2 * err_y >= dh_reg) begin
            tex_row = tex_row + 1'b1;
            err_y = err_y - dh_reg;
          end
        end
        row = row + 1'b1;
        if (row >= row_end) begin
          busy = 1'b0;
        end else if (!(th_reg < dh_reg) && !advance_to_sampled_row()) begin
          busy = 1'b0;
        end
        if (busy) begin
          begin_row();
        end
      end else if (!(tw_reg < dw_reg)) begin
        tex_col = tex_col + 1'b1;
      end
    end
    if (busy) begin
      res.fetch_x = tex_col;
      res.fetch_y = tex_row;
    end else begin
      res.done_res = 1'b1;
    end
    return res;
  endfunction

  function automatic blit_res_t make_res(logic we, logic [CB-1:0] px, logic [CB-1:0] py,
                                         logic [PB-1:0] data, logic [CB:0] fx,
                                         logic [CB:0] fy, logic done);
    blit_res_t res;
    res.write_enable = we;
    res.pixel_x = px;
    res.pixel_y = py;
    res.pixel_data = data;
    res.fetch_x = fx;
    res.fetch_y = fy;
    res.done_res = done;
    return res;
  endfunction

  function automatic blit_req_t start_req(logic [CB-1:0] sx, logic [CB-1:0] sy,
                                          logic [CB-1:0] tx, logic [CB-1:0] ty);
    blit_req_t r;
    r = '0;
    r.req_type = REQ_START;
    r.start_x = sx;
    r.start_y = sy;
    r.tex_origin_x = tx;
    r.tex_origin_y = ty;
    return r;
  endfunction

  function automatic blit_req_t texel_req(logic [PB-1:0] value);
    blit_req_t r;
    r = '0;
    r.req_type = REQ_TEXEL;
    r.texel = value;
    return r;
  endfunction

  function automatic plan_row_t req_step(blit_req_t r);
    plan_row_t p;
    p.kind = ROW_REQ;
    p.reg_idx = '0;
    p.value = '0;
    p.req = r;
    p.checked = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic plan_row_t checked_step(blit_req_t r, blit_res_t want);
    plan_row_t p;
    p = req_step(r);
    p.checked = 1'b1;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t reg_step(logic [REG_IDX_BITS-1:0] idx,
                                         logic [DATA_BITS-1:0] value);
    plan_row_t p;
    p = req_step('0);
    p.kind = ROW_CFG;
    p.reg_idx = idx;
    p.value = value;
    return p;
  endfunction

  // Large spans start close to the clip bound so that the clipped span stays short.
  function automatic logic [CB-1:0] pick_origin(int span, int bound);
    if (span > 16 && bound > 0) begin
      return CB'($urandom_range(bound - 1, (bound > 8) ? bound - 8 : 0));
    end
    if (bound > 0 && bound < 4096 && $urandom_range(0, 1) == 1) begin
      return CB'($urandom_range(0, bound - 1));
    end
    return CB'($urandom);
  endfunction

  function automatic blit_req_t random_start_req();
    blit_req_t r;
    r.req_type = REQ_START;
    r.start_x = pick_origin(dw_reg, sw_reg);
    r.start_y = pick_origin(dh_reg, sh_reg);
    r.tex_origin_x = CB'($urandom);
    r.tex_origin_y = CB'($urandom);
    r.texel = $urandom;
    return r;
  endfunction

  function automatic blit_req_t random_texel_req();
    blit_req_t r;
    r.req_type = REQ_TEXEL;
    r.start_x = CB'($urandom);
    r.start_y = CB'($urandom);
    r.tex_origin_x = CB'($urandom);
    r.tex_origin_y = CB'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: r.texel = key_reg;
      3: r.texel = key_reg ^ (32'd1 << $urandom_range(0, 31));
      default: r.texel = $urandom;
    endcase
    return r;
  endfunction

  function automatic int pick_size(bit wide);
    if (wide) begin
      case ($urandom_range(0, 2))
        0: return 4095;
        1: return 1;
        default: ;
      endcase
    end
    return $urandom_range(1, 8);
  endfunction

  task automatic send_req(input blit_req_t r, input bit typed, input blit_res_t want);
    blit_res_t predicted;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.req_type;
    in_start_x <= r.start_x;
    in_start_y <= r.start_y;
    in_tex_origin_x <= r.tex_origin_x;
    in_tex_origin_y <= r.tex_origin_y;
    in_texel <= r.texel;
    do @(posedge clk); while (!in_ready);
    predicted = step_blitter(r);
    results_due.push_back(typed ? want : predicted);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEST_WIDTH: dw_reg = int'(value[CB-1:0]);
      REG_DEST_HEIGHT: dh_reg = int'(value[CB-1:0]);
      REG_TEX_WIDTH: tw_reg = int'(value[CB-1:0]);
      REG_TEX_HEIGHT: th_reg = int'(value[CB-1:0]);
      REG_KEY_COLOR: key_reg = value[PB-1:0];
      REG_SCREEN_WIDTH: sw_reg = int'(value[CB:0]);
      REG_SCREEN_HEIGHT: sh_reg = int'(value[CB:0]);
      default: ;
    endcase
  endtask

  task automatic configure_blit(input bit wide);
    int span;
    span = pick_size(wide);
    reg_write(REG_DEST_WIDTH, span);
    reg_write(REG_TEX_WIDTH, (span == 4095) ? pick_size(1'b1) : $urandom_range(1, 8));
    reg_write(REG_DEST_HEIGHT, pick_size(wide));
    reg_write(REG_TEX_HEIGHT, pick_size(wide));
    case ($urandom_range(0, 3))
      0: reg_write(REG_KEY_COLOR, '0);
      1: reg_write(REG_KEY_COLOR, '1);
      default: reg_write(REG_KEY_COLOR, $urandom);
    endcase
    reg_write(REG_SCREEN_WIDTH, ($urandom_range(0, 9) < 7) ? 4096 : $urandom_range(0, 4096));
    reg_write(REG_SCREEN_HEIGHT, ($urandom_range(0, 9) < 7) ? 4096 : $urandom_range(0, 4096));
  endtask

  task automatic check_field(input string name, input logic [PB-1:0] want,
                             input logic [PB-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    blit_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, got we %0b (%0d,%0d) %0h",
                 $time, out_write_enable, out_pixel_x, out_pixel_y, out_pixel_data);
      end else begin
        want = results_due.pop_front();
        check_field("write_enable", 32'(want.write_enable), 32'(out_write_enable));
        check_field("pixel_x", 32'(want.pixel_x), 32'(out_pixel_x));
        check_field("pixel_y", 32'(want.pixel_y), 32'(out_pixel_y));
        check_field("pixel_data", want.pixel_data, out_pixel_data);
        check_field("fetch_x", 32'(want.fetch_x), 32'(out_fetch_x));
        check_field("fetch_y", 32'(want.fetch_y), 32'(out_fetch_y));
        check_field("done_res", 32'(want.done_res), 32'(out_done_res));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A texel with no blit running, then one-pixel blits at the reset sizes.
    directed_plan.push_back(checked_step(texel_req('1), make_res(0, 0, 0, 0, 0, 0, 1)));
    directed_plan.push_back(checked_step(start_req(0, 0, 0, 0), make_res(0, 0, 0, 0, 1, 1, 0)));
    directed_plan.push_back(checked_step(texel_req('1), make_res(1, 0, 0, '1, 0, 0, 1)));
    directed_plan.push_back(checked_step(start_req('1, '1, '1, '1),
                                         make_res(0, 0, 0, 0, 4096, 4096, 0)));
    directed_plan.push_back(checked_step(texel_req('0), make_res(0, 0, 0, 0, 0, 0, 1)));
    directed_plan.push_back(req_step(start_req(5, 7, 100, 200)));
    directed_plan.push_back(req_step(start_req(9, 3, 1, 2)));
    directed_plan.push_back(req_step(texel_req(32'haaaa_5555)));
    // Empty rectangles from a zero clip bound and from a zero width.
    directed_plan.push_back(reg_step(REG_SCREEN_WIDTH, 0));
    directed_plan.push_back(checked_step(start_req(100, 100, 0, 0),
                                         make_res(0, 0, 0, 0, 0, 0, 1)));
    directed_plan.push_back(reg_step(REG_SCREEN_WIDTH, 4096));
    directed_plan.push_back(reg_step(REG_DEST_WIDTH, 0));
    directed_plan.push_back(checked_step(start_req(0, 0, 0, 0), make_res(0, 0, 0, 0, 0, 0, 1)));
    // Horizontal upscale with vertical downscale, and a key change in the middle.
    directed_plan.push_back(reg_step(REG_DEST_WIDTH, 3));
    directed_plan.push_back(reg_step(REG_DEST_HEIGHT, 2));
    directed_plan.push_back(reg_step(REG_TEX_HEIGHT, 5));
    directed_plan.push_back(reg_step(REG_KEY_COLOR, 32'h1234_5678));
    directed_plan.push_back(req_step(start_req(10, 20, 30, 40)));
    directed_plan.push_back(req_step(texel_req(32'h1234_5678)));
    directed_plan.push_back(req_step(texel_req(32'h5555_aaaa)));
    directed_plan.push_back(req_step(texel_req(32'h0000_0001)));
    directed_plan.push_back(reg_step(REG_KEY_COLOR, 32'h5555_aaaa));
    directed_plan.push_back(req_step(texel_req(32'h5555_aaaa)));
    directed_plan.push_back(req_step(texel_req(32'h1234_5678)));
    directed_plan.push_back(req_step(texel_req(32'h8000_0000)));
    // Horizontal downscale with skipped columns at the screen corner.
    directed_plan.push_back(reg_step(REG_DEST_WIDTH, 2));
    directed_plan.push_back(reg_step(REG_DEST_HEIGHT, 1));
    directed_plan.push_back(reg_step(REG_TEX_WIDTH, 3));
    directed_plan.push_back(req_step(start_req(4094, 4095, 7, 9)));
    directed_plan.push_back(req_step(texel_req(32'h0f0f_0f0f)));
    directed_plan.push_back(req_step(texel_req(32'hf0f0_f0f0)));
    directed_plan.push_back(req_step(texel_req(32'h7fff_ffff)));

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        wait_for_results();
        reg_write(directed_plan[i].reg_idx, directed_plan[i].value);
      end else begin
        send_req(directed_plan[i].req, directed_plan[i].checked, directed_plan[i].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_results();
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 51;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 51;
        end
        default: begin
          gap_pct = 8;
          stall_pct = 8;
        end
      endcase
      configure_blit(p == 3 || p == 6);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 19) == 0) begin
          send_req(random_texel_req(), 1'b0, '0);
        end
        send_req(random_start_req(), 1'b0, '0);
        sent++;
        while (busy) begin
          if ($urandom_range(0, 99) == 0) begin
            send_req(random_start_req(), 1'b0, '0);
          end else begin
            send_req(random_texel_req(), 1'b0, '0);
          end
          sent++;
        end
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
